// ===== hw/rtl/lsft_pkg.sv =====
// shared types and constants of the label subset forwarding table
package lsft_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_RES       = 16;
    localparam int MATCH_W       = $clog2(MAX_RES + 1);
    localparam int LABEL_W       = 48;
    localparam int ADDR_W        = 64;
    localparam int IDX_OUT_W     = 4;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 64;

    typedef enum logic [1:0] {
        MODE_MERGE     = 2'd0,
        MODE_DELETE    = 2'd1,
        MODE_FORWARD   = 2'd2,
        MODE_AGGREGATE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_OWN_LO = 1'b0,
        CFG_OWN_HI = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_mode              mode;
        logic [ADDR_W-1:0]  addr_hi;
        logic [ADDR_W-1:0]  addr_lo;
        logic [LABEL_W-1:0] labels_lo;
        logic [LABEL_W-1:0] labels_hi;
    } t_in_beat;

    typedef struct packed {
        t_status              status;
        logic                 hit;
        logic [IDX_OUT_W-1:0] entry_index;
        logic [ADDR_W-1:0]    nbr_addr_hi;
        logic [ADDR_W-1:0]    nbr_addr_lo;
        logic [LABEL_W-1:0]   merged_lo;
        logic [LABEL_W-1:0]   merged_hi;
        logic                 last;
    } t_out_beat;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr_hi;
        logic [ADDR_W-1:0]  addr_lo;
        logic [LABEL_W-1:0] labels_lo;
        logic [LABEL_W-1:0] labels_hi;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== hw/rtl/label_subset_forwarding_table_top.sv =====
// top level of the label subset forwarding table
//
// Neighbor table of NUM_SLOTS entries, each a 128-bit address and a 96-bit label mask.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one request beat: merge,
// delete, forward match or aggregate. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns the result beats; the final beat of a request has last set.
// Merge, delete and aggregate give one beat; forward gives one beat per matching
// valid entry in slot order (at most 16), or one beat without hit.
// Each request scans the slot ram one entry per cycle through its single read port
// while not stalled. o_in_ready is low from acceptance until the final step is done,
// so the next request is accepted only once the previous one has finished its final
// step. A stalled receiver holds the scan when a forward result is waiting for the
// output register, and holds the final step.
// The output register lets the last beat wait while the next request is accepted.
// Own label registers sit on an APB port: offset 0 words 0 to 2, offset 8 words 3 to 5.
// Reset clears the valid bits, the own labels and the output valid flag; ram contents
// are not cleared and are only read through a valid entry.
module label_subset_forwarding_table_top #(
    parameter int NUM_SLOTS = lsft_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lsft_pkg::t_in_beat              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lsft_pkg::t_out_beat             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsft_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lsft_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lsft_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                            r_state;
    lsft_pkg::t_in_beat                r_req;
    logic [CNT_W-1:0]                  r_idx;
    logic                              r_chk_v;
    logic [IDX_W-1:0]                  r_chk_idx;
    logic                              r_found;
    logic [IDX_W-1:0]                  r_slot;
    logic                              r_free_f;
    logic [IDX_W-1:0]                  r_free;
    logic                              r_pend;
    logic [IDX_W-1:0]                  r_pend_idx;
    logic [lsft_pkg::ADDR_W-1:0]       r_pend_hi;
    logic [lsft_pkg::ADDR_W-1:0]       r_pend_lo;
    logic [lsft_pkg::MATCH_W-1:0]      r_nmatch;
    logic [lsft_pkg::LABEL_W-1:0]      r_acc_lo;
    logic [lsft_pkg::LABEL_W-1:0]      r_acc_hi;
    logic [NUM_SLOTS-1:0]              r_valid;
    logic [lsft_pkg::LABEL_W-1:0]      r_own_lo;
    logic [lsft_pkg::LABEL_W-1:0]      r_own_hi;
    logic                              r_out_valid;
    lsft_pkg::t_out_beat               r_out;

    lsft_pkg::t_out_beat               n_beat;
    logic [lsft_pkg::ENTRY_W-1:0]      ram_q;
    lsft_pkg::t_entry                  rd;
    lsft_pkg::t_entry                  wr;
    logic                              in_fire;
    logic                              out_busy;
    logic                              slot_ok;
    logic                              addr_hit;
    logic                              lbl_hit;
    logic                              fwd_take;
    logic                              stall;
    logic                              scan_go;
    logic                              issue;
    logic                              push;
    logic                              fin_go;
    logic                              ram_we;
    logic [IDX_W-1:0]                  ram_waddr;
    logic                              cfg_wr;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_busy = r_out_valid && !i_out_ready;
    assign rd       = lsft_pkg::t_entry'(ram_q);

    assign slot_ok  = r_chk_v && r_valid[r_chk_idx];
    assign addr_hit = slot_ok && (rd.addr_hi == r_req.addr_hi)
                      && (rd.addr_lo == r_req.addr_lo);
    assign lbl_hit  = slot_ok && ((rd.labels_lo & r_req.labels_lo) == r_req.labels_lo)
                      && ((rd.labels_hi & r_req.labels_hi) == r_req.labels_hi);
    assign fwd_take = (r_req.mode == lsft_pkg::MODE_FORWARD) && lbl_hit
                      && (r_nmatch < lsft_pkg::MATCH_W'(lsft_pkg::MAX_RES));
    assign stall    = fwd_take && r_pend && out_busy;
    assign scan_go  = (r_state == S_SCAN) && !stall;
    assign issue    = scan_go && (r_idx < CNT_W'(NUM_SLOTS));
    assign fin_go   = (r_state == S_FIN) && !out_busy;

    assign wr.addr_hi   = r_req.addr_hi;
    assign wr.addr_lo   = r_req.addr_lo;
    assign wr.labels_lo = r_req.labels_lo;
    assign wr.labels_hi = r_req.labels_hi;
    assign ram_we    = fin_go && (r_req.mode == lsft_pkg::MODE_MERGE) && (r_found || r_free_f);
    assign ram_waddr = r_found ? r_slot : r_free;

    lsft_ram #(
        .WIDTH  (lsft_pkg::ENTRY_W),
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr),
        .i_re    (issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_q)
    );

    // result beat selection
    always_comb begin
        push   = 1'b0;
        n_beat = '0;
        if ((r_state == S_SCAN) && fwd_take && r_pend && !out_busy) begin
            push               = 1'b1;
            n_beat.hit         = 1'b1;
            n_beat.entry_index = lsft_pkg::IDX_OUT_W'(r_pend_idx);
            n_beat.nbr_addr_hi = r_pend_hi;
            n_beat.nbr_addr_lo = r_pend_lo;
        end else if (fin_go) begin
            push        = 1'b1;
            n_beat.last = 1'b1;
            case (r_req.mode)
                lsft_pkg::MODE_MERGE: begin
                    if (r_found || r_free_f) begin
                        n_beat.entry_index = lsft_pkg::IDX_OUT_W'(ram_waddr);
                        n_beat.nbr_addr_hi = r_req.addr_hi;
                        n_beat.nbr_addr_lo = r_req.addr_lo;
                    end else begin
                        n_beat.status = lsft_pkg::STATUS_FULL;
                    end
                end
                lsft_pkg::MODE_DELETE: begin
                    if (r_found) begin
                        n_beat.entry_index = lsft_pkg::IDX_OUT_W'(r_slot);
                        n_beat.nbr_addr_hi = r_req.addr_hi;
                        n_beat.nbr_addr_lo = r_req.addr_lo;
                    end else begin
                        n_beat.status = lsft_pkg::STATUS_NOT_FOUND;
                    end
                end
                lsft_pkg::MODE_FORWARD: begin
                    if (r_pend) begin
                        n_beat.hit         = 1'b1;
                        n_beat.entry_index = lsft_pkg::IDX_OUT_W'(r_pend_idx);
                        n_beat.nbr_addr_hi = r_pend_hi;
                        n_beat.nbr_addr_lo = r_pend_lo;
                    end
                end
                default: begin
                    n_beat.merged_lo = r_acc_lo;
                    n_beat.merged_hi = r_acc_hi;
                end
            endcase
        end
    end

    // sequencer and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chk_v <= 1'b0;
            r_valid <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_req    <= i_in_data;
                        r_idx    <= '0;
                        r_chk_v  <= 1'b0;
                        r_found  <= 1'b0;
                        r_free_f <= 1'b0;
                        r_pend   <= 1'b0;
                        r_nmatch <= '0;
                        r_acc_lo <= r_own_lo;
                        r_acc_hi <= r_own_hi;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_go) begin
                        r_chk_v   <= issue;
                        r_chk_idx <= r_idx[IDX_W-1:0];
                        if (issue) begin
                            r_idx <= r_idx + CNT_W'(1);
                        end else begin
                            r_state <= S_FIN;
                        end
                        if (addr_hit && !r_found) begin
                            r_found <= 1'b1;
                            r_slot  <= r_chk_idx;
                        end
                        if (r_chk_v && !r_valid[r_chk_idx] && !r_free_f) begin
                            r_free_f <= 1'b1;
                            r_free   <= r_chk_idx;
                        end
                        if (fwd_take) begin
                            r_pend     <= 1'b1;
                            r_pend_idx <= r_chk_idx;
                            r_pend_hi  <= rd.addr_hi;
                            r_pend_lo  <= rd.addr_lo;
                            r_nmatch   <= r_nmatch + lsft_pkg::MATCH_W'(1);
                        end
                        if (slot_ok) begin
                            r_acc_lo <= r_acc_lo | rd.labels_lo;
                            r_acc_hi <= r_acc_hi | rd.labels_hi;
                        end
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        if (ram_we) begin
                            r_valid[ram_waddr] <= 1'b1;
                        end
                        if ((r_req.mode == lsft_pkg::MODE_DELETE) && r_found) begin
                            r_valid[r_slot] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
            r_out       <= n_beat;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_lo <= '0;
            r_own_hi <= '0;
        end else if (cfg_wr) begin
            case (lsft_pkg::t_cfg_idx'(paddr[3]))
                lsft_pkg::CFG_OWN_LO: r_own_lo <= pwdata[lsft_pkg::LABEL_W-1:0];
                lsft_pkg::CFG_OWN_HI: r_own_hi <= pwdata[lsft_pkg::LABEL_W-1:0];
                default: begin
                    r_own_lo <= r_own_lo;
                end
            endcase
        end
    end

    always_comb begin
        case (lsft_pkg::t_cfg_idx'(paddr[3]))
            lsft_pkg::CFG_OWN_LO: prdata = lsft_pkg::CFG_DATA_W'(r_own_lo);
            lsft_pkg::CFG_OWN_HI: prdata = lsft_pkg::CFG_DATA_W'(r_own_hi);
            default:              prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a scan");

    a_fin_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_state == S_IDLE) && o_out_valid && o_out_data.last)
        else $error("final step did not present a last beat");

    a_stall_holds_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && stall |=> $stable(r_idx) && $stable(r_pend_idx))
        else $error("scan moved while stalled");

    a_mid_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> (r_state == S_SCAN) || (r_state == S_FIN))
        else $error("non-last beat pending while idle");
`endif

endmodule

// ===== hw/rtl/lsft_ram.sv =====
// generic single write port ram with registered read
module lsft_ram #(
    parameter int WIDTH  = lsft_pkg::ENTRY_W,
    parameter int DEPTH  = lsft_pkg::NUM_SLOTS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== tb/sv/label_subset_forwarding_table_top_tb.sv =====
// testbench of the label subset forwarding table: directed and random requests vs a table model
module label_subset_forwarding_table_top_tb;

    localparam int SLOTS       = lsft_pkg::NUM_SLOTS_DEF;
    localparam int POOL        = 24;
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [lsft_pkg::LABEL_W-1:0] ONES48 = '1;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    lsft_pkg::t_in_beat              in_data  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    lsft_pkg::t_out_beat             out_data;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [lsft_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [lsft_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [lsft_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    logic                           tbl_valid   [SLOTS];
    logic [lsft_pkg::ADDR_W-1:0]    tbl_addr_hi [SLOTS];
    logic [lsft_pkg::ADDR_W-1:0]    tbl_addr_lo [SLOTS];
    logic [lsft_pkg::LABEL_W-1:0]   tbl_lbl_lo  [SLOTS];
    logic [lsft_pkg::LABEL_W-1:0]   tbl_lbl_hi  [SLOTS];
    logic [lsft_pkg::LABEL_W-1:0]   own_lo = '0;
    logic [lsft_pkg::LABEL_W-1:0]   own_hi = '0;
    logic [lsft_pkg::ADDR_W-1:0]    pool_hi [POOL];
    logic [lsft_pkg::ADDR_W-1:0]    pool_lo [POOL];
    logic [2*lsft_pkg::LABEL_W-1:0] label_pool [8];

    lsft_pkg::t_in_beat  pending_requests[$];
    lsft_pkg::t_out_beat expected_results[$];

    int   in_gap     = 0;
    int   out_gap    = 0;
    int   mismatches = 0;
    int   cycles     = 0;
    logic quiet      = 1'b0;

    label_subset_forwarding_table_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [2*lsft_pkg::LABEL_W-1:0] rand96();
        return {$urandom, $urandom, $urandom};
    endfunction

    // table update and expected beats for one accepted request
    function automatic void predict_table_op(input lsft_pkg::t_in_beat b);
        lsft_pkg::t_out_beat          r;
        int                           slot;
        int                           hits;
        logic [lsft_pkg::LABEL_W-1:0] acc_lo;
        logic [lsft_pkg::LABEL_W-1:0] acc_hi;
        r      = '0;
        r.last = 1'b1;
        slot   = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (tbl_valid[i] && tbl_addr_hi[i] == b.addr_hi && tbl_addr_lo[i] == b.addr_lo)
                slot = i;
        case (b.mode)
            lsft_pkg::MODE_MERGE: begin
                if (slot < 0)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!tbl_valid[i])
                            slot = i;
                if (slot < 0) begin
                    r.status = lsft_pkg::STATUS_FULL;
                end else begin
                    tbl_valid[slot]   = 1'b1;
                    tbl_addr_hi[slot] = b.addr_hi;
                    tbl_addr_lo[slot] = b.addr_lo;
                    tbl_lbl_lo[slot]  = b.labels_lo;
                    tbl_lbl_hi[slot]  = b.labels_hi;
                    r.entry_index     = lsft_pkg::IDX_OUT_W'(slot);
                    r.nbr_addr_hi     = b.addr_hi;
                    r.nbr_addr_lo     = b.addr_lo;
                end
                expected_results.push_back(r);
            end
            lsft_pkg::MODE_DELETE: begin
                if (slot < 0) begin
                    r.status = lsft_pkg::STATUS_NOT_FOUND;
                end else begin
                    tbl_valid[slot] = 1'b0;
                    r.entry_index   = lsft_pkg::IDX_OUT_W'(slot);
                    r.nbr_addr_hi   = b.addr_hi;
                    r.nbr_addr_lo   = b.addr_lo;
                end
                expected_results.push_back(r);
            end
            lsft_pkg::MODE_FORWARD: begin
                hits = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (hits < lsft_pkg::MAX_RES && tbl_valid[i] &&
                        (tbl_lbl_lo[i] & b.labels_lo) == b.labels_lo &&
                        (tbl_lbl_hi[i] & b.labels_hi) == b.labels_hi) begin
                        r             = '0;
                        r.hit         = 1'b1;
                        r.entry_index = lsft_pkg::IDX_OUT_W'(i);
                        r.nbr_addr_hi = tbl_addr_hi[i];
                        r.nbr_addr_lo = tbl_addr_lo[i];
                        expected_results.push_back(r);
                        hits++;
                    end
                end
                if (hits == 0) begin
                    r      = '0;
                    r.last = 1'b1;
                end else begin
                    r      = expected_results.pop_back();
                    r.last = 1'b1;
                end
                expected_results.push_back(r);
            end
            default: begin
                acc_lo = own_lo;
                acc_hi = own_hi;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_valid[i]) begin
                        acc_lo = acc_lo | tbl_lbl_lo[i];
                        acc_hi = acc_hi | tbl_lbl_hi[i];
                    end
                r.merged_lo = acc_lo;
                r.merged_hi = acc_hi;
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // a negative pool index asks for a fully random address
    function automatic void push_request(input lsft_pkg::t_mode m, input int a,
                                         input logic [2*lsft_pkg::LABEL_W-1:0] lbl);
        lsft_pkg::t_in_beat b;
        b.mode      = m;
        b.addr_hi   = (a < 0) ? rand64() : pool_hi[a];
        b.addr_lo   = (a < 0) ? rand64() : pool_lo[a];
        b.labels_lo = lbl[lsft_pkg::LABEL_W-1:0];
        b.labels_hi = lbl[2*lsft_pkg::LABEL_W-1:lsft_pkg::LABEL_W];
        pending_requests.push_back(b);
    endfunction

    function automatic void queue_random_requests(input int count);
        int                             pick;
        int                             sel;
        int                             a;
        lsft_pkg::t_mode                m;
        logic [2*lsft_pkg::LABEL_W-1:0] lbl;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            m    = (pick < 7) ? lsft_pkg::MODE_MERGE : (pick < 12) ? lsft_pkg::MODE_DELETE :
                   (pick < 18) ? lsft_pkg::MODE_FORWARD : lsft_pkg::MODE_AGGREGATE;
            sel  = $urandom_range(0, 9);
            if (m == lsft_pkg::MODE_FORWARD)
                lbl = (sel < 3) ? '0 :
                      (sel < 8) ? (label_pool[$urandom_range(0, 7)] & rand96()) : rand96();
            else
                lbl = (sel < 7) ? label_pool[$urandom_range(0, 7)] : rand96();
            a = ($urandom_range(0, 19) < 17) ? int'($urandom_range(0, POOL - 1)) : -1;
            push_request(m, a, lbl);
        end
    endfunction

    task automatic write_reg(input lsft_pkg::t_cfg_idx idx,
                             input logic [lsft_pkg::LABEL_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= lsft_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == lsft_pkg::CFG_OWN_LO)
            own_lo = value;
        else
            own_hi = value;
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid)
                predict_table_op(in_data);
            if (in_gap > 0) begin
                in_gap   = in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= pending_requests.pop_front();
                if (!quiet && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 15);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        lsft_pkg::t_out_beat e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: st=%0d hit=%0d idx=%0d last=%0d",
                                 out_data.status, out_data.hit, out_data.entry_index,
                                 out_data.last);
                end else begin
                    e = expected_results.pop_front();
                    if (out_data.status !== e.status || out_data.hit !== e.hit ||
                        out_data.entry_index !== e.entry_index ||
                        out_data.nbr_addr_hi !== e.nbr_addr_hi ||
                        out_data.nbr_addr_lo !== e.nbr_addr_lo ||
                        out_data.merged_lo !== e.merged_lo ||
                        out_data.merged_hi !== e.merged_hi || out_data.last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp: st=%0d hit=%0d idx=%0d addr=%h_%h m=%h_%h l=%0d",
                                     e.status, e.hit, e.entry_index, e.nbr_addr_hi,
                                     e.nbr_addr_lo, e.merged_hi, e.merged_lo, e.last);
                            $display("         got: st=%0d hit=%0d idx=%0d addr=%h_%h m=%h_%h l=%0d",
                                     out_data.status, out_data.hit, out_data.entry_index,
                                     out_data.nbr_addr_hi, out_data.nbr_addr_lo,
                                     out_data.merged_hi, out_data.merged_lo, out_data.last);
                        end
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap   = out_gap - 1;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_gap   = $urandom_range(0, 14);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL label_subset_forwarding_table_top");
            $finish;
        end
    end

    initial begin
        foreach (tbl_valid[i]) begin
            tbl_valid[i]   = 1'b0;
            tbl_addr_hi[i] = '0;
            tbl_addr_lo[i] = '0;
            tbl_lbl_lo[i]  = '0;
            tbl_lbl_hi[i]  = '0;
        end
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        for (int i = 2; i < POOL; i++) begin
            pool_hi[i] = rand64();
            pool_lo[i] = rand64();
        end
        label_pool[0] = '1;
        label_pool[1] = '0;
        for (int i = 2; i < 6; i++)
            label_pool[i] = rand96() & rand96();
        label_pool[6] = rand96();
        label_pool[7] = rand96();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(lsft_pkg::CFG_OWN_LO, '0);
        write_reg(lsft_pkg::CFG_OWN_HI, '0);
        // empty table cases
        push_request(lsft_pkg::MODE_AGGREGATE, 2, '0);
        push_request(lsft_pkg::MODE_FORWARD, 2, '0);
        push_request(lsft_pkg::MODE_DELETE, 1, '0);
        // new entries, then a label update of an existing one
        push_request(lsft_pkg::MODE_MERGE, 1, '1);
        push_request(lsft_pkg::MODE_MERGE, 0, '0);
        push_request(lsft_pkg::MODE_MERGE, 1, {48'h0, 48'hA5A5_A5A5_A5A5});
        push_request(lsft_pkg::MODE_FORWARD, 2, '1);
        push_request(lsft_pkg::MODE_FORWARD, 2, '0);
        push_request(lsft_pkg::MODE_DELETE, 0, '0);
        // fill every slot, the freed one first
        for (int a = 2; a < 17; a++)
            push_request(lsft_pkg::MODE_MERGE, a, a[0] ? '1 : label_pool[a % 8]);
        push_request(lsft_pkg::MODE_MERGE, 17, '1);
        push_request(lsft_pkg::MODE_FORWARD, 2, '0);
        push_request(lsft_pkg::MODE_FORWARD, 2, '1);
        push_request(lsft_pkg::MODE_AGGREGATE, 2, '0);
        drain();

        write_reg(lsft_pkg::CFG_OWN_LO, ONES48);
        write_reg(lsft_pkg::CFG_OWN_HI, '0);
        queue_random_requests(48);
        drain();

        write_reg(lsft_pkg::CFG_OWN_LO, lsft_pkg::LABEL_W'(rand64()));
        write_reg(lsft_pkg::CFG_OWN_HI, lsft_pkg::LABEL_W'(rand64()));
        queue_random_requests(47);
        drain();

        quiet <= 1'b1;
        write_reg(lsft_pkg::CFG_OWN_LO, '0);
        write_reg(lsft_pkg::CFG_OWN_HI, ONES48);
        queue_random_requests(47);
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS label_subset_forwarding_table_top");
        else
            $display("FAIL label_subset_forwarding_table_top");
        $finish;
    end

endmodule
